// ===== src/url_percent_decoder_defines.svh =====
`ifndef URL_PERCENT_DECODER_DEFINES_SVH
`define URL_PERCENT_DECODER_DEFINES_SVH

// Concurrent checks clocked on clk_i and switched off while reset is asserted.
`define UPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define UPD_ASSERT_IMP(lbl, ante, cons, msg) \
  `UPD_ASSERT(lbl, (ante) |-> (cons), msg)

`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `UPD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== src/upd_pkg.sv =====
package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef enum logic [1:0] {
    PhNormal = 2'd0,
    PhEsc1   = 2'd1,
    PhEsc2   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            str_end;
  } run_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_status_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// ===== src/upd_req_if.sv =====
interface upd_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

// ===== src/upd_res_if.sv =====
interface upd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

// ===== src/url_percent_decoder.sv =====
// Percent decoder for escaped URL text, one byte per request on req_i.
// Each request carries in_byte and final_byte, set on the last byte of a string.
// Results leave on res_o as out_byte with run_last, set on the last result of a
// request, and string_end, set on the last result of the whole string.
// cfg_we_i writes cfg_wdata_i into the plus-to-space option; write it only while
// the decoder is idle.
// A request is taken in the cycle it arrives while the run queue has room. Its
// results are classified in that cycle and written into the run queue, whose head
// is shown on res_o. The back end sends one result per cycle while res_o is ready,
// so a request with k results holds the output until all k are sent; requests with
// at most one result flow at one per cycle. The four-entry run queue between the
// two parts absorbs the extra cycles of escapes that flush two or three bytes.
// When res_o stalls, the current result holds and requests keep being taken until
// the queue fills, after which req_i.ready falls.
// Reset empties the queue, clears any pending escape and turns the option off.
module url_percent_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_req_if.sink   req_i,
  upd_res_if.source res_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  upd_pkg::run_t      push_run;
  upd_pkg::run_t      head_run;
  upd_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  upd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_status.full),
    .push_o      (push),
    .run_o       (push_run)
  );

  upd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_run),
    .pop_i       (pop),
    .head_o      (head_run),
    .status_o    (q_status)
  );

  upd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_run),
    .head_valid_i (q_status.head_valid),
    .pop_o        (pop),
    .res_o        (res_o)
  );

endmodule

// ===== src/upd_front.sv =====
module upd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  upd_req_if.sink           req_i,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              q_full_i,
  output logic              push_o,
  output upd_pkg::run_t     run_o
);

  upd_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_q, held_d;
  logic            plus_q;
  logic            accept;
  logic            run_normal;
  logic [1:0]      n;
  logic [2:0][7:0] b;
  logic [7:0]      c;
  logic            c_hex;

  assign req_i.ready = !q_full_i;
  assign accept      = req_i.valid && !q_full_i;
  assign c           = req_i.in_byte;
  assign c_hex       = upd_pkg::is_hex(c);

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    n          = 2'd0;
    b          = '0;
    run_normal = 1'b0;
    case (phase_q)
      upd_pkg::PhEsc1: begin
        if (c_hex) begin
          held_d  = c;
          phase_d = upd_pkg::PhEsc2;
        end else begin
          b[0]       = upd_pkg::ChPercent;
          n          = 2'd1;
          run_normal = 1'b1;
        end
      end
      upd_pkg::PhEsc2: begin
        if (c_hex) begin
          b[0]    = {upd_pkg::hex_nibble(held_q), upd_pkg::hex_nibble(c)};
          n       = 2'd1;
          phase_d = upd_pkg::PhNormal;
        end else begin
          b[0]       = upd_pkg::ChPercent;
          b[1]       = held_q;
          n          = 2'd2;
          run_normal = 1'b1;
        end
      end
      default: begin
        run_normal = 1'b1;
      end
    endcase
    if (run_normal) begin
      if (c == upd_pkg::ChPercent) begin
        phase_d = upd_pkg::PhEsc1;
      end else begin
        b[n]    = (c == upd_pkg::ChPlus && plus_q) ? upd_pkg::ChSpace : c;
        n       = n + 2'd1;
        phase_d = upd_pkg::PhNormal;
      end
    end
    if (req_i.final_byte) begin
      if (phase_d == upd_pkg::PhEsc1) begin
        b[n] = upd_pkg::ChPercent;
        n    = n + 2'd1;
      end else if (phase_d == upd_pkg::PhEsc2) begin
        b[0] = upd_pkg::ChPercent;
        b[1] = held_d;
        n    = 2'd2;
      end
      phase_d = upd_pkg::PhNormal;
    end
  end

  assign push_o        = accept && (n != 2'd0);
  assign run_o.cnt     = n;
  assign run_o.bytes   = b;
  assign run_o.str_end = req_i.final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PhNormal;
      held_q  <= 8'd0;
      plus_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        held_q  <= held_d;
      end
      if (cfg_we_i) begin
        plus_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== src/upd_queue.sv =====
module upd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  upd_pkg::run_t        push_data_i,
  input  logic                 pop_i,
  output upd_pkg::run_t        head_o,
  output upd_pkg::q_status_t   status_o
);

  upd_pkg::run_t              mem_q [upd_pkg::QDepth];
  logic [upd_pkg::QAw-1:0]    wr_q, rd_q;
  logic [upd_pkg::QAw:0]      cnt_q, cnt_d;
  logic                       do_pop;

  assign status_o.full       = (cnt_q == (upd_pkg::QAw+1)'(upd_pkg::QDepth));
  assign status_o.head_valid = (cnt_q != '0);
  assign head_o              = mem_q[rd_q];
  assign do_pop              = pop_i && status_o.head_valid;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

endmodule

// ===== src/upd_back.sv =====
module upd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  upd_pkg::run_t  head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  upd_res_if.source      res_o
);

  logic [1:0] pos_q;
  logic       last;
  logic       fire;

  assign last           = (pos_q == head_i.cnt - 2'd1);
  assign fire           = head_valid_i && res_o.ready;
  assign pop_o          = fire && last;
  assign res_o.valid    = head_valid_i;
  assign res_o.out_byte = head_i.bytes[pos_q];
  assign res_o.run_last = last;
  assign res_o.string_end = last && head_i.str_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
    end else if (fire) begin
      pos_q <= last ? 2'd0 : pos_q + 2'd1;
    end
  end

endmodule

// ===== src/upd_checker.sv =====
`include "url_percent_decoder_defines.svh"

module upd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_final,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       string_end
);

  `UPD_ASSERT_IMP(a_end_is_run_last, out_valid && string_end, run_last, "string end without run end")
  `UPD_ASSERT_NEXT(a_final_gives_result, in_valid && in_ready && in_final && !out_valid, out_valid, "final byte gave no result")
  `UPD_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last), "stalled result changed")

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .in_final   (req_i.final_byte),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_byte   (res_o.out_byte),
  .run_last   (res_o.run_last),
  .string_end (res_o.string_end)
);
